@@ sv/mctd_pkg.sv @@
// Package: shared constants, types and register codes of the trigger debouncer.
package mctd_pkg;

  localparam int CHANNELS  = 10;
  localparam int TIME_BITS = 32;
  localparam int CHAN_W    = 4;
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [CFG_W-1:0] RESET_DEBOUNCE = CFG_W'(5);
  localparam logic [CFG_W-1:0] RESET_REST     = CFG_W'(60);

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REST     = CFG_IDX_W'(1);

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [IDX_W-1:0] idx;
    logic             level;
  } op_t;

endpackage

@@ sv/mctd_ifs.sv @@
// Interfaces: input item, trigger result and configuration write channels.
interface mctd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [mctd_pkg::CHAN_W-1:0] channel;
  logic                      pin_level;
  modport source (output valid, command, channel, pin_level, input ready);
  modport sink   (input valid, command, channel, pin_level, output ready);
endinterface

interface mctd_out_if;
  logic                      valid;
  logic                      ready;
  logic [mctd_pkg::CHAN_W-1:0] trigger_channel;
  modport source (output valid, trigger_channel, input ready);
  modport sink   (input valid, trigger_channel, output ready);
endinterface

interface mctd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mctd_pkg::CFG_IDX_W-1:0] index;
  logic [mctd_pkg::CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mctd_front.sv @@
// Front end: accept input items, classify them and drop unmapped edges.
module mctd_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [mctd_pkg::CHAN_W-1:0] channel,
  input  logic                        pin_level,
  output logic                        push,
  output mctd_pkg::op_t               push_op,
  input  logic                        q_full
);
  import mctd_pkg::*;

  logic mapped;

  assign mapped   = (channel != '0) && (32'(channel) <= CHANNELS);
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && ((command == CMD_TICK) || mapped);

  always_comb begin
    push_op.kind  = (command == CMD_TICK) ? OP_TICK : OP_EDGE;
    push_op.idx   = IDX_W'(channel - CHAN_W'(1));
    push_op.level = pin_level;
  end

endmodule

@@ sv/mctd_queue.sv @@
// Short FIFO of classified operations between front and back end.
module mctd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mctd_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output mctd_pkg::op_t head_op
);
  import mctd_pkg::*;

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full    = (32'(count) == Q_DEPTH);
  assign q_valid = (count != '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == Q_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == Q_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/mctd_back.sv @@
// Back end: time counter, per-channel lock cells, config registers, result register.
module mctd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  mctd_pkg::op_t                  head_op,
  output logic                           pop,
  input  logic                           cfg_valid,
  input  logic [mctd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mctd_pkg::CFG_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mctd_pkg::CHAN_W-1:0]    trigger_channel
);
  import mctd_pkg::*;

  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] rest_ticks;
  time_t            now_ticks;
  time_t            last_edge_time [CHANNELS];
  time_t            unlock_time    [CHANNELS];
  logic             channel_locked [CHANNELS];

  time_t now_next;
  time_t sel_last;
  time_t since_last;
  logic  sel_locked;
  logic  do_tick;
  logic  do_edge;
  logic  resting;
  logic  fire;
  logic  expired [CHANNELS];

  assign pop      = q_valid && (!out_valid || out_ready);
  assign do_tick  = pop && (head_op.kind == OP_TICK);
  assign do_edge  = pop && (head_op.kind == OP_EDGE);
  assign now_next = now_ticks + 1'b1;

  assign sel_last   = last_edge_time[head_op.idx];
  assign sel_locked = channel_locked[head_op.idx];
  assign since_last = now_ticks - sel_last;
  assign resting    = since_last < TIME_BITS'(rest_ticks);
  assign fire       = do_edge && !sel_locked && !resting && !head_op.level;

  // Wrap-safe expiry: released once now has reached unlock time.
  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      time_t elapsed;
      elapsed    = now_next - unlock_time[k];
      expired[k] = channel_locked[k] && !elapsed[TIME_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= RESET_DEBOUNCE;
      rest_ticks     <= RESET_REST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEBOUNCE) begin
        debounce_ticks <= cfg_data;
      end else if (cfg_index == REG_REST) begin
        rest_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        last_edge_time[k] <= '0;
        unlock_time[k]    <= '0;
        channel_locked[k] <= 1'b0;
      end
    end else if (do_tick) begin
      now_ticks <= now_next;
      for (int k = 0; k < CHANNELS; k++) begin
        if (expired[k]) begin
          channel_locked[k] <= 1'b0;
          last_edge_time[k] <= now_next;
        end
      end
    end else if (do_edge && !sel_locked) begin
      last_edge_time[head_op.idx] <= now_ticks;
      if (fire) begin
        channel_locked[head_op.idx] <= 1'b1;
        unlock_time[head_op.idx]    <= now_ticks + TIME_BITS'(debounce_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      trigger_channel <= CHAN_W'(32'(head_op.idx) + 1);
    end
  end

endmodule

@@ sv/multi_channel_trigger_debouncer.sv @@
// Top level: ten-channel trigger qualifier with debounce lockout and rest period.
//
//   channel   role    payload                          handshake
//   items     sink    command, channel, pin_level      valid/ready
//   triggers  source  trigger_channel                  valid/ready
//   cfg       sink    index, data                      valid/ready (ready tied high)
//
// An accepted item is written into a two-entry queue and is executed by the back
// end once it is at the head and the trigger output is not stalled; one item per
// cycle is sustained while triggers are taken; the trigger valid is registered.
// Synchronous reset clears the time counter, all channel cells and the queue and
// loads the register defaults. A stalled trigger output blocks the back end only;
// the front keeps accepting until the queue fills.
module multi_channel_trigger_debouncer (
  input logic        clk,
  input logic        rst,
  mctd_in_if.sink    items,
  mctd_out_if.source triggers,
  mctd_cfg_if.sink   cfg
);
  import mctd_pkg::*;

  logic push;
  op_t  push_op;
  logic q_full;
  logic pop;
  logic q_valid;
  op_t  head_op;

  // Config writes are always taken.
  assign cfg.ready = 1'b1;

  // Classify items; unmapped edges are dropped here.
  mctd_front u_front (
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .command   (items.command),
    .channel   (items.channel),
    .pin_level (items.pin_level),
    .push      (push),
    .push_op   (push_op),
    .q_full    (q_full)
  );

  // Decouple acceptance from execution.
  mctd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head_op (head_op)
  );

  // Execute ticks and edges, hold the trigger until taken.
  mctd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .head_op         (head_op),
    .pop             (pop),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (triggers.valid),
    .out_ready       (triggers.ready),
    .trigger_channel (triggers.trigger_channel)
  );

endmodule
